### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DQKS_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("deque checker: implication failed");

// Next-cycle implication, disabled while reset is high.
`define DQKS_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("deque checker: next-cycle implication failed");

`endif

### hw/rtl/dqks_pkg.sv
// Package for the deque with key search: field widths, operation and status codes,
// and the sequencer state type. Depends on nothing.
package dqks_pkg;

  localparam int DQKS_DEPTH = 16;
  localparam int FUNC_W     = 3;
  localparam int KEY_W      = 32;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 4;
  localparam int OCC_W      = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SEARCH     = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_SCAN
  } state_t;

endpackage

### hw/rtl/dqks_ram.sv
// Key store of the deque: one address per cycle, a write if enabled and a registered read.
// Depends on dqks_pkg for the key width.
module dqks_ram #(
  parameter int DEPTH = dqks_pkg::DQKS_DEPTH,
  parameter int AW    = $clog2(dqks_pkg::DQKS_DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     addr,
  input  logic signed [dqks_pkg::KEY_W-1:0] wdata,
  output logic signed [dqks_pkg::KEY_W-1:0] rdata
);
  import dqks_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/deque_with_key_search.sv
// A bounded double-ended queue of signed 32-bit keys in a circular store of DEPTH
// entries. Pulse start with func and key while busy is low; the transaction is taken
// at that edge and busy rises. The result appears on status, key_out, position and
// occupancy, marked by done for exactly one cycle, and cannot be held off: capture it
// then. Pushes, taken or refused, pops or searches of an empty queue and unused codes
// give done from the execute state; a pop goes through the execute and pop states; a
// search goes on to the scan state, where one comparator walks the store one entry per
// cycle behind its single registered read port until a match or the last of at most
// DEPTH entries. A new transaction may be started in the cycle in which done is high.
// Depends on dqks_pkg and dqks_ram.
module deque_with_key_search #(
  parameter int DEPTH = dqks_pkg::DQKS_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [dqks_pkg::FUNC_W-1:0]        func,
  input  logic signed [dqks_pkg::KEY_W-1:0]  key,
  output logic                               busy,
  output logic                               done,
  output logic [dqks_pkg::STAT_W-1:0]        status,
  output logic signed [dqks_pkg::KEY_W-1:0]  key_out,
  output logic [dqks_pkg::POS_W-1:0]         position,
  output logic [dqks_pkg::OCC_W-1:0]         occupancy
);
  import dqks_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  func_t func_q;
  logic signed [KEY_W-1:0] key_q;

  logic [AW-1:0]  offset;
  logic [AW:0]    sum;
  logic [AW:0]    slot;
  logic [AW-1:0]  ram_addr;
  logic           ram_we;
  logic signed [KEY_W-1:0] ram_rdata;

  logic full, empty, match, last;
  logic res_load;
  status_t res_status;
  logic signed [KEY_W-1:0] res_key;
  logic [AW-1:0] res_pos;

  assign busy = (state != ST_IDLE);

  // Shared address unit: head plus an offset, wrapped into the store.
  assign sum      = {1'b0, head} + {1'b0, offset};
  assign slot     = (sum >= (AW+1)'(DEPTH)) ? (sum - (AW+1)'(DEPTH)) : sum;
  assign ram_addr = slot[AW-1:0];

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign match = (ram_rdata == key_q);
  assign last  = ((CW'(idx) + CW'(1)) == count);

  dqks_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (key_q),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (func_q)
          FN_POP_FRONT, FN_POP_BACK: state_next = empty ? ST_IDLE : ST_POP;
          FN_SEARCH:                 state_next = empty ? ST_IDLE : ST_SCAN;
          default:                   state_next = ST_IDLE;
        endcase
      end
      ST_POP: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (match || last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    offset     = '0;
    ram_we     = 1'b0;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_key    = '0;
    res_pos    = '0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        unique case (func_q)
          FN_PUSH_FRONT: begin
            res_load = 1'b1;
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              offset     = AW'(DEPTH - 1);
              ram_we     = 1'b1;
              head_next  = ram_addr;
              count_next = count + CW'(1);
            end
          end
          FN_PUSH_BACK: begin
            res_load = 1'b1;
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              offset     = count[AW-1:0];
              ram_we     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          FN_POP_FRONT: begin
            if (empty) begin
              res_load   = 1'b1;
              res_status = STAT_EMPTY;
            end
          end
          FN_POP_BACK: begin
            if (empty) begin
              res_load   = 1'b1;
              res_status = STAT_EMPTY;
            end else begin
              offset = AW'(count - CW'(1));
            end
          end
          FN_SEARCH: begin
            idx_next = '0;
            if (empty) begin
              res_load   = 1'b1;
              res_status = STAT_EMPTY;
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      ST_POP: begin
        res_load   = 1'b1;
        res_key    = ram_rdata;
        count_next = count - CW'(1);
        if (func_q == FN_POP_FRONT) begin
          // The address unit is free this cycle, so it advances the head.
          offset    = AW'(1);
          head_next = ram_addr;
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_load = 1'b1;
          res_pos  = idx;
        end else if (last) begin
          res_load   = 1'b1;
          res_status = STAT_MISS;
        end else begin
          idx_next = idx + AW'(1);
          offset   = idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_q <= func_t'(func);
      key_q  <= key;
    end
    idx <= idx_next;
    if (res_load) begin
      status    <= res_status;
      key_out   <= res_key;
      position  <= POS_W'(res_pos);
      occupancy <= OCC_W'(count_next);
    end
  end

endmodule

### hw/rtl/dqks_check.sv
// Port-level checker for the deque with key search, and its bind to the top level.
// Depends on dqks_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dqks_check #(
  parameter int DEPTH = dqks_pkg::DQKS_DEPTH
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [dqks_pkg::STAT_W-1:0]       status,
  input logic signed [dqks_pkg::KEY_W-1:0] key_out,
  input logic [dqks_pkg::POS_W-1:0]        position,
  input logic [dqks_pkg::OCC_W-1:0]        occupancy
);
  import dqks_pkg::*;

  // A delivered result always leaves the block free for the next transaction.
  `DQKS_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)

  // An accepted transaction keeps the block busy in the following cycle.
  `DQKS_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)

  // A push can only be refused when the store is completely full.
  `DQKS_ASSERT_IMP(a_full_occ, clk, rst, done && (status == STAT_FULL),
                   occupancy == OCC_W'(DEPTH))

  // An empty report means nothing is held and no key is returned.
  `DQKS_ASSERT_IMP(a_empty_occ, clk, rst, done && (status == STAT_EMPTY),
                   (occupancy == '0) && (key_out == '0))

  // A failed search reports position zero.
  `DQKS_ASSERT_IMP(a_miss_pos, clk, rst, done && (status == STAT_MISS),
                   position == '0)

endmodule

bind deque_with_key_search dqks_check #(
  .DEPTH (DEPTH)
) u_dqks_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .key_out   (key_out),
  .position  (position),
  .occupancy (occupancy)
);

### dv/tb_deque_with_key_search.sv
// Self-checking testbench for deque_with_key_search: a shadow deque predicts every
// reply, which is then compared with what the block reports on its done strobe.
// Depends on dqks_pkg and the deque_with_key_search RTL.
`timescale 1ns / 1ps

module tb_deque_with_key_search;
  import dqks_pkg::*;

  localparam int          DEPTH           = DQKS_DEPTH;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int          SETTLE_CYCLES   = 24;
  localparam int          PHASE_ITEMS     = 106;
  localparam int          MAX_REPORTED    = 10;
  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LAST_CODE    = 3'd7;

  typedef struct {
    status_t                  status;
    logic signed [KEY_W-1:0]  key_out;
    logic [POS_W-1:0]         position;
    logic [OCC_W-1:0]         occupancy;
  } deque_reply_t;

  // Shadow copy of the deque; each accepted transaction queues the reply it must give.
  class deque_mirror;
    bit [KEY_W-1:0] slots [DEPTH];
    int unsigned    head;
    int unsigned    count;
    deque_reply_t   pending_replies [$];
    int unsigned    mismatches;

    function void take_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k);
      deque_reply_t r;
      int unsigned  i;
      bit           hit;
      r.status   = STAT_OK;
      r.key_out  = '0;
      r.position = '0;
      case (fn)
        FN_PUSH_FRONT: begin
          if (count == DEPTH) r.status = STAT_FULL;
          else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = k;
            count++;
          end
        end
        FN_PUSH_BACK: begin
          if (count == DEPTH) r.status = STAT_FULL;
          else begin
            slots[(head + count) % DEPTH] = k;
            count++;
          end
        end
        FN_POP_FRONT: begin
          if (count == 0) r.status = STAT_EMPTY;
          else begin
            r.key_out = slots[head];
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        FN_POP_BACK: begin
          if (count == 0) r.status = STAT_EMPTY;
          else begin
            r.key_out = slots[(head + count - 1) % DEPTH];
            count--;
          end
        end
        FN_SEARCH: begin
          if (count == 0) r.status = STAT_EMPTY;
          else begin
            hit = 1'b0;
            for (i = 0; i < count && !hit; i++) begin
              if (slots[(head + i) % DEPTH] == k) begin
                hit = 1'b1;
                r.position = POS_W'(i);
              end
            end
            r.status = hit ? STAT_OK : STAT_MISS;
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(count);
      pending_replies.push_back(r);
    endfunction

    function void fault(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTED) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void check_reply(logic [STAT_W-1:0] st, logic signed [KEY_W-1:0] kout,
                              logic [POS_W-1:0] pos, logic [OCC_W-1:0] occ);
      deque_reply_t e;
      if (pending_replies.size() == 0) begin
        fault($sformatf("reply with no transaction outstanding: status %0d key %0d", st, kout));
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status || kout !== e.key_out || pos !== e.position ||
          occ !== e.occupancy)
        fault($sformatf("exp status %0d key %0d pos %0d occ %0d, got %0d %0d %0d %0d",
                        e.status, e.key_out, e.position, e.occupancy,
                        st, kout, pos, occ));
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction

    function logic [KEY_W-1:0] held_key();
      return slots[(head + $urandom_range(count - 1, 0)) % DEPTH];
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [FUNC_W-1:0]        func = '0;
  logic signed [KEY_W-1:0]  key = '0;
  logic                     busy;
  logic                     done;
  logic [STAT_W-1:0]        status;
  logic signed [KEY_W-1:0]  key_out;
  logic [POS_W-1:0]         position;
  logic [OCC_W-1:0]         occupancy;

  deque_mirror mirror = new();
  int unsigned cycles = 0;
  bit          filling = 1'b1;

  deque_with_key_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .key       (key),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .key_out   (key_out),
    .position  (position),
    .occupancy (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_deque_with_key_search failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.check_reply(status, key_out, position, occupancy);
  end

  // Holds start high until the transaction is taken at an edge with busy low.
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k);
    @(negedge clk);
    start <= 1'b1;
    func  <= fn;
    key   <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.take_request(fn, k);
  endtask

  task automatic idle_for(input int pct);
    while ($urandom_range(99, 0) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (mirror.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    int unsigned r;
    r = $urandom_range(9, 0);
    case (r)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(7, 0);  // small keys give duplicates
      default: return $urandom;
    endcase
  endfunction

  // Pushes dominate while filling and pops while emptying, so the deque swings
  // between empty and full and the head index wraps in both directions.
  task automatic random_request();
    int unsigned      r;
    logic [KEY_W-1:0] k;
    if (mirror.count == DEPTH && $urandom_range(3, 0) != 0) filling = 1'b0;
    if (mirror.count == 0 && $urandom_range(3, 0) != 0) filling = 1'b1;
    if ($urandom_range(19, 0) == 0) filling = ~filling;
    r = $urandom_range(99, 0);
    if (r < 3) begin
      send_request(FUNC_W'(FN_FIRST_UNUSED +
                           $urandom_range(FN_LAST_CODE - FN_FIRST_UNUSED, 0)), $urandom);
    end else if (r < 25) begin
      if (mirror.count != 0 && $urandom_range(1, 0) == 0) k = mirror.held_key();
      else k = fresh_key();
      send_request(FN_SEARCH, k);
    end else if ((r < 68) == filling) begin
      send_request($urandom_range(1, 0) ? FN_PUSH_FRONT : FN_PUSH_BACK, fresh_key());
    end else begin
      send_request($urandom_range(1, 0) ? FN_POP_FRONT : FN_POP_BACK, $urandom);
    end
  endtask

  initial begin
    int               idle_pct [4];
    int               p;
    int               n;
    logic [FUNC_W-1:0] c;
    logic [KEY_W-1:0] last_front;
    logic [KEY_W-1:0] last_back;
    idle_pct = '{0, 52, 0, 35};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Empty deque: both pops and a search must report empty.
    send_request(FN_POP_FRONT, 32'h0);
    send_request(FN_POP_BACK, $urandom);
    send_request(FN_SEARCH, $urandom);
    send_request(FN_PUSH_BACK, 32'h7fff_ffff);
    send_request(FN_PUSH_FRONT, 32'h8000_0000);
    send_request(FN_PUSH_BACK, 32'h0);
    send_request(FN_PUSH_FRONT, 32'hffff_ffff);
    for (n = 0; n < 12; n++) begin
      if (n % 2 == 0) begin
        last_front = $urandom;
        send_request(FN_PUSH_FRONT, last_front);
      end else begin
        last_back = $urandom;
        send_request(FN_PUSH_BACK, last_back);
      end
    end
    // Full deque: pushes at either end are refused.
    send_request(FN_PUSH_FRONT, $urandom);
    send_request(FN_PUSH_BACK, $urandom);
    send_request(FN_SEARCH, last_front);
    send_request(FN_SEARCH, last_back);
    send_request(FN_SEARCH, 32'h5a5a_a5a5);
    for (c = FN_FIRST_UNUSED; c != FN_PUSH_FRONT; c++) send_request(c, $urandom);

    for (p = 0; p < 4; p++) begin
      drain_replies();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        idle_for(idle_pct[p]);
        random_request();
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("tb_deque_with_key_search passed");
    end else begin
      $display("tb_deque_with_key_search failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/dqks_pkg.sv
hw/rtl/dqks_ram.sv
hw/rtl/deque_with_key_search.sv
hw/rtl/dqks_check.sv
dv/tb_deque_with_key_search.sv
